// ===== rtl/multilevel_priority_fifo_macros.svh =====
// Assertion macros used by the checker.
`ifndef MULTILEVEL_PRIORITY_FIFO_MACROS_SVH
`define MULTILEVEL_PRIORITY_FIFO_MACROS_SVH

// Property sampled on the rising edge, off while reset is high.
`define MLPF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MLPF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mlpf_pkg.sv =====
package mlpf_pkg;

   localparam int LEVELS_DEF     = 8;
   localparam int POOL_DEPTH_DEF = 64;
   localparam int KEY_WIDTH_DEF  = 32;

   localparam int KEY_PORT_W = 32;
   localparam int PRIO_W     = 3;
   localparam int OCC_W      = 7;
   localparam int STATUS_W   = 2;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_PUSHED = 2'd0,
      STAT_POPPED = 2'd1,
      STAT_FULL   = 2'd2,
      STAT_EMPTY  = 2'd3
   } status_type;

   // level table write controls
   typedef struct packed {
      logic head_we;
      logic tail_we;
      logic ne_set;
      logic ne_clr;
   } lvl_ctl_type;

endpackage

// ===== rtl/mlpf_ram.sv =====
module mlpf_ram #(
   parameter int WIDTH = mlpf_pkg::KEY_WIDTH_DEF,
   parameter int DEPTH = mlpf_pkg::POOL_DEPTH_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   // read-first: same-address write returns old data
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rd_ff <= mem_ff[addr];
   end

   assign rdata = rd_ff;

endmodule

// ===== rtl/mlpf_level_tab.sv =====
module mlpf_level_tab #(
   parameter int LEVELS = mlpf_pkg::LEVELS_DEF,
   parameter int NW     = $clog2(mlpf_pkg::POOL_DEPTH_DEF),
   localparam int LW    = $clog2(LEVELS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [LW-1:0]        rd_lvl,
   output logic [NW-1:0]        rd_head,
   output logic [NW-1:0]        rd_tail,
   output logic [LEVELS-1:0]    nonempty,
   input  mlpf_pkg::lvl_ctl_type ctl,
   input  logic [LW-1:0]        wr_lvl,
   input  logic [NW-1:0]        head_data,
   input  logic [NW-1:0]        tail_data
);

   logic [NW-1:0]     heads_ff [LEVELS];
   logic [NW-1:0]     tails_ff [LEVELS];
   logic [LEVELS-1:0] ne_ff;
   logic [LEVELS-1:0] ne_in;

   always_comb begin
      ne_in = ne_ff;
      if (ctl.ne_set) begin
         ne_in[wr_lvl] = 1'b1;
      end
      if (ctl.ne_clr) begin
         ne_in[wr_lvl] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ne_ff <= '0;
      end else begin
         ne_ff <= ne_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.head_we) begin
         heads_ff[wr_lvl] <= head_data;
      end
      if (ctl.tail_we) begin
         tails_ff[wr_lvl] <= tail_data;
      end
   end

   assign rd_head  = heads_ff[rd_lvl];
   assign rd_tail  = tails_ff[rd_lvl];
   assign nonempty = ne_ff;

endmodule

// ===== rtl/multilevel_priority_fifo.sv =====
// Strict-priority queue, one FIFO per level over a shared pool of linked nodes.
// Command channel: a word (req_cmd, req_key, req_priority_req) is taken at a
// rising edge with start high and busy low. Push appends req_key at the tail
// of its level (levels at or above LEVELS go to the last level); pop takes the
// head of the lowest-numbered non-empty level.
// Result channel: rsp_valid is high for one cycle with rsp_status, rsp_out_key,
// rsp_out_priority and rsp_occupancy (keys queued after the command).
// A full pool on push or an empty queue on pop reports status and occupancy, zero key and priority.
// The accepting edge moves the control to S_FIN; the result registers load at
// the edge that ends S_FIN and hold the result for the receiver. No new
// command is taken while busy; busy is high for the cycle after accept, when
// the link read from the node memory (next free node or next head) lands and
// is written back.
// Reset: the queue is empty, the pool unused; no clearing pass is needed.
// The receiver cannot stall: each result is shown once and must be taken.
module multilevel_priority_fifo #(
   parameter int LEVELS     = mlpf_pkg::LEVELS_DEF,
   parameter int POOL_DEPTH = mlpf_pkg::POOL_DEPTH_DEF,
   parameter int KEY_WIDTH  = mlpf_pkg::KEY_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_cmd,
   input  logic [mlpf_pkg::KEY_PORT_W-1:0] req_key,
   input  logic [mlpf_pkg::PRIO_W-1:0]     req_priority_req,
   output logic                            rsp_valid,
   output logic [mlpf_pkg::STATUS_W-1:0]   rsp_status,
   output logic [mlpf_pkg::KEY_PORT_W-1:0] rsp_out_key,
   output logic [mlpf_pkg::PRIO_W-1:0]     rsp_out_priority,
   output logic [mlpf_pkg::OCC_W-1:0]      rsp_occupancy
);

   localparam int NW = $clog2(POOL_DEPTH);
   localparam int CW = $clog2(POOL_DEPTH + 1);
   localparam int LW = $clog2(LEVELS);
   localparam int KW = (KEY_WIDTH < mlpf_pkg::KEY_PORT_W) ? KEY_WIDTH : mlpf_pkg::KEY_PORT_W;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_FIN  = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [NW-1:0] rec_head_ff, rec_head_in;
   logic [CW-1:0] rec_cnt_ff, rec_cnt_in;
   logic [CW-1:0] fresh_ff, fresh_in;
   logic [CW-1:0] queued_ff, queued_in;

   logic          op_pop_ff, op_pop_in;
   logic          ok_ff, ok_in;
   logic          rec_pend_ff, rec_pend_in;
   logic          link_pend_ff, link_pend_in;
   logic          hd_pend_ff, hd_pend_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [NW-1:0] node_ff, node_in;
   logic [NW-1:0] old_tail_ff, old_tail_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   mlpf_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [mlpf_pkg::KEY_PORT_W-1:0] rsp_key_ff, rsp_key_in;
   logic [mlpf_pkg::PRIO_W-1:0]     rsp_prio_ff, rsp_prio_in;
   logic [mlpf_pkg::OCC_W-1:0]      rsp_occ_ff, rsp_occ_in;

   logic          accept, cmd_pop;
   logic [LW-1:0] push_lvl, pop_lvl, sel_lvl, wr_lvl;
   logic          have_rec, have_fresh, push_ok, pop_ok;
   logic [NW-1:0] new_node;

   logic [NW-1:0]     lt_head, lt_tail;
   logic [LEVELS-1:0] lt_ne;
   mlpf_pkg::lvl_ctl_type lt_ctl;
   logic [NW-1:0]     lt_head_data, lt_tail_data;

   logic          key_we;
   logic [NW-1:0] key_addr;
   logic [KW-1:0] key_rdata;
   logic          link_we;
   logic [NW-1:0] link_addr, link_wdata, link_rdata;

   mlpf_ram #(.WIDTH(KW), .DEPTH(POOL_DEPTH)) u_keys (
      .clock (clock),
      .we    (key_we),
      .addr  (key_addr),
      .wdata (req_key[KW-1:0]),
      .rdata (key_rdata)
   );

   mlpf_ram #(.WIDTH(NW), .DEPTH(POOL_DEPTH)) u_links (
      .clock (clock),
      .we    (link_we),
      .addr  (link_addr),
      .wdata (link_wdata),
      .rdata (link_rdata)
   );

   mlpf_level_tab #(.LEVELS(LEVELS), .NW(NW)) u_levels (
      .clock     (clock),
      .reset     (reset),
      .rd_lvl    (sel_lvl),
      .rd_head   (lt_head),
      .rd_tail   (lt_tail),
      .nonempty  (lt_ne),
      .ctl       (lt_ctl),
      .wr_lvl    (wr_lvl),
      .head_data (lt_head_data),
      .tail_data (lt_tail_data)
   );

   assign busy    = (state_ff == S_FIN);
   assign accept  = start && !busy;
   assign cmd_pop = (req_cmd == mlpf_pkg::CMD_POP);

   assign push_lvl   = (32'(req_priority_req) >= LEVELS) ? LW'(LEVELS - 1)
                                                         : LW'(req_priority_req);
   assign sel_lvl    = cmd_pop ? pop_lvl : push_lvl;
   assign have_rec   = (rec_cnt_ff != '0);
   assign have_fresh = (fresh_ff < CW'(POOL_DEPTH));
   assign push_ok    = have_rec || have_fresh;
   assign pop_ok     = |lt_ne;
   assign new_node   = have_rec ? rec_head_ff : fresh_ff[NW-1:0];

   // lowest-numbered non-empty level
   always_comb begin
      pop_lvl = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (lt_ne[i]) begin
            pop_lvl = LW'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      rec_head_in  = rec_head_ff;
      rec_cnt_in   = rec_cnt_ff;
      fresh_in     = fresh_ff;
      queued_in    = queued_ff;
      op_pop_in    = op_pop_ff;
      ok_in        = ok_ff;
      rec_pend_in  = rec_pend_ff;
      link_pend_in = link_pend_ff;
      hd_pend_in   = hd_pend_ff;
      lvl_in       = lvl_ff;
      node_in      = node_ff;
      old_tail_in  = old_tail_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_prio_in  = rsp_prio_ff;
      rsp_occ_in   = rsp_occ_ff;

      key_we       = 1'b0;
      key_addr     = cmd_pop ? lt_head : new_node;
      link_we      = 1'b0;
      link_addr    = cmd_pop ? lt_head : new_node;
      link_wdata   = '0;
      lt_ctl       = '0;
      wr_lvl       = sel_lvl;
      lt_head_data = new_node;
      lt_tail_data = new_node;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in     = S_FIN;
               op_pop_in    = cmd_pop;
               lvl_in       = sel_lvl;
               node_in      = new_node;
               old_tail_in  = lt_tail;
               rec_pend_in  = 1'b0;
               link_pend_in = 1'b0;
               hd_pend_in   = 1'b0;
               if (!cmd_pop) begin
                  ok_in = push_ok;
                  if (push_ok) begin
                     key_we       = 1'b1;
                     link_we      = 1'b1;
                     rec_pend_in  = have_rec;
                     link_pend_in = lt_ne[push_lvl];
                     queued_in    = queued_ff + CW'(1);
                     if (have_rec) begin
                        rec_cnt_in = rec_cnt_ff - CW'(1);
                     end else begin
                        fresh_in = fresh_ff + CW'(1);
                     end
                     lt_ctl.tail_we = 1'b1;
                     if (!lt_ne[push_lvl]) begin
                        lt_ctl.head_we = 1'b1;
                        lt_ctl.ne_set  = 1'b1;
                     end
                  end
               end else begin
                  ok_in = pop_ok;
                  if (pop_ok) begin
                     link_we     = 1'b1;
                     link_wdata  = rec_head_ff;
                     rec_head_in = lt_head;
                     rec_cnt_in  = rec_cnt_ff + CW'(1);
                     if (queued_ff != '0) begin
                        queued_in = queued_ff - CW'(1);
                     end
                     if (lt_head == lt_tail) begin
                        lt_ctl.ne_clr = 1'b1;
                     end else begin
                        hd_pend_in = 1'b1;
                     end
                  end
               end
            end
         end
         S_FIN: begin
            state_in = S_IDLE;
            wr_lvl   = lvl_ff;
            if (rec_pend_ff) begin
               rec_head_in = link_rdata;
            end
            if (link_pend_ff) begin
               link_we    = 1'b1;
               link_addr  = old_tail_ff;
               link_wdata = node_ff;
            end
            if (hd_pend_ff) begin
               lt_ctl.head_we = 1'b1;
               lt_head_data   = link_rdata;
            end
            rsp_valid_in = 1'b1;
            rsp_key_in   = '0;
            rsp_prio_in  = '0;
            rsp_occ_in   = mlpf_pkg::OCC_W'(queued_ff);
            if (op_pop_ff) begin
               rsp_status_in = ok_ff ? mlpf_pkg::STAT_POPPED : mlpf_pkg::STAT_EMPTY;
               if (ok_ff) begin
                  rsp_key_in  = mlpf_pkg::KEY_PORT_W'(key_rdata);
                  rsp_prio_in = mlpf_pkg::PRIO_W'(lvl_ff);
               end
            end else begin
               rsp_status_in = ok_ff ? mlpf_pkg::STAT_PUSHED : mlpf_pkg::STAT_FULL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rec_head_ff  <= '0;
         rec_cnt_ff   <= '0;
         fresh_ff     <= '0;
         queued_ff    <= '0;
         op_pop_ff    <= 1'b0;
         ok_ff        <= 1'b0;
         rec_pend_ff  <= 1'b0;
         link_pend_ff <= 1'b0;
         hd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rec_head_ff  <= rec_head_in;
         rec_cnt_ff   <= rec_cnt_in;
         fresh_ff     <= fresh_in;
         queued_ff    <= queued_in;
         op_pop_ff    <= op_pop_in;
         ok_ff        <= ok_in;
         rec_pend_ff  <= rec_pend_in;
         link_pend_ff <= link_pend_in;
         hd_pend_ff   <= hd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff        <= lvl_in;
      node_ff       <= node_in;
      old_tail_ff   <= old_tail_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_key      = rsp_key_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_occupancy    = rsp_occ_ff;

endmodule

// ===== rtl/mlpf_checker.sv =====
`include "multilevel_priority_fifo_macros.svh"

module mlpf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic [mlpf_pkg::STATUS_W-1:0]   rsp_status,
   input logic [mlpf_pkg::KEY_PORT_W-1:0] rsp_out_key,
   input logic [mlpf_pkg::PRIO_W-1:0]     rsp_out_priority,
   input logic [mlpf_pkg::OCC_W-1:0]      rsp_occupancy
);

   `MLPF_ASSERT(a_latency, (start && !busy) |-> ##2 rsp_valid, "result not 2 cycles after accept")
   `MLPF_ASSERT_NEXT(a_busy_one, busy, !busy, "busy held longer than one cycle")
   `MLPF_ASSERT(a_empty_occ, (rsp_valid && rsp_status == mlpf_pkg::STAT_EMPTY) |-> (rsp_occupancy == '0), "empty pop with nonzero occupancy")
   `MLPF_ASSERT(a_zero_payload, (rsp_valid && rsp_status != mlpf_pkg::STAT_POPPED) |-> (rsp_out_key == '0 && rsp_out_priority == '0), "payload on non-pop result")

endmodule

bind multilevel_priority_fifo mlpf_checker u_mlpf_checker (.*);

// ===== verif/tb_multilevel_priority_fifo.sv =====
module tb_multilevel_priority_fifo;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEVELS     = mlpf_pkg::LEVELS_DEF;
   localparam int POOL_DEPTH = mlpf_pkg::POOL_DEPTH_DEF;
   localparam int KEY_WIDTH  = mlpf_pkg::KEY_WIDTH_DEF;
   localparam int KPW        = mlpf_pkg::KEY_PORT_W;
   localparam int PW         = mlpf_pkg::PRIO_W;
   localparam int OW         = mlpf_pkg::OCC_W;
   localparam int SW         = mlpf_pkg::STATUS_W;
   localparam logic [KPW-1:0] KEY_MASK = {KPW{1'b1}} >> (KPW - KEY_WIDTH);

   typedef struct {
      mlpf_pkg::status_type status;
      logic [KPW-1:0]       key;
      logic [PW-1:0]        prio;
      logic [OW-1:0]        occ;
   } fifo_result_type;

   class queue_tracker;
      logic [KPW-1:0]  level_keys[LEVELS][$];
      int              queued;
      fifo_result_type pending_results[$];
      int              errors;

      function new();
         queued = 0;
         errors = 0;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      task report_mismatch(string field, logic [KPW-1:0] exp_val,
                           logic [KPW-1:0] got_val);
         if (errors < 40)
            $display("MISMATCH %s: expected %0h got %0h at %0t", field, exp_val, got_val, $realtime);
         errors++;
      endtask

      function void note_command(mlpf_pkg::cmd_type c, logic [KPW-1:0] k, logic [PW-1:0] p);
         fifo_result_type r;
         int              lvl;
         r = '{mlpf_pkg::STAT_EMPTY, '0, '0, '0};
         if (c == mlpf_pkg::CMD_PUSH) begin
            lvl = (p >= LEVELS) ? LEVELS - 1 : p;
            if (queued == POOL_DEPTH) begin
               r.status = mlpf_pkg::STAT_FULL;
            end else begin
               level_keys[lvl].push_back(k & KEY_MASK);
               queued++;
               r.status = mlpf_pkg::STAT_PUSHED;
            end
         end else begin
            for (lvl = 0; lvl < LEVELS; lvl++)
               if (level_keys[lvl].size() != 0) break;
            if (lvl < LEVELS) begin
               r.key    = level_keys[lvl].pop_front();
               r.prio   = PW'(lvl);
               r.status = mlpf_pkg::STAT_POPPED;
               queued--;
            end
         end
         r.occ = OW'(queued);
         pending_results.push_back(r);
      endfunction

      task check_result(logic [SW-1:0] s, logic [KPW-1:0] k,
                        logic [PW-1:0] p, logic [OW-1:0] o);
         fifo_result_type e;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected word, status", '0, KPW'(s));
         end else begin
            e = pending_results.pop_front();
            if (s !== e.status) report_mismatch("status", KPW'(e.status), KPW'(s));
            if (k !== e.key) report_mismatch("out_key", e.key, k);
            if (p !== e.prio) report_mismatch("out_priority", KPW'(e.prio), KPW'(p));
            if (o !== e.occ) report_mismatch("occupancy", KPW'(e.occ), KPW'(o));
         end
      endtask
   endclass

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           start = 1'b0;
   logic           busy;
   logic           req_cmd = 1'b0;
   logic [KPW-1:0] req_key = '0;
   logic [PW-1:0]  req_priority_req = '0;
   logic           rsp_valid;
   logic [SW-1:0]  rsp_status;
   logic [KPW-1:0] rsp_out_key;
   logic [PW-1:0]  rsp_out_priority;
   logic [OW-1:0]  rsp_occupancy;

   queue_tracker tracker = new();
   int           words_sent = 0;

   multilevel_priority_fifo i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_key          (req_key),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_key      (rsp_out_key),
      .rsp_out_priority (rsp_out_priority),
      .rsp_occupancy    (rsp_occupancy)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         tracker.check_result(rsp_status, rsp_out_key, rsp_out_priority, rsp_occupancy);
   end

   initial begin
      #1ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [KPW-1:0] random_key();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_word(mlpf_pkg::cmd_type c, logic [KPW-1:0] k, logic [PW-1:0] p);
      int gap;
      gap = 0;
      // steady stretch with back-to-back words
      if (!(words_sent >= 400 && words_sent < 600) && $urandom_range(0, 99) < 25)
         gap = $urandom_range(1, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_cmd          <= c;
      req_key          <= k;
      req_priority_req <= p;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      tracker.note_command(c, k, p);
      words_sent++;
   endtask

   task automatic drain_wait();
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic run_burst(int length, int push_pct, bit narrow);
      logic [PW-1:0] lvl_a;
      logic [PW-1:0] lvl_b;
      logic [PW-1:0] p;
      lvl_a = PW'($urandom_range(0, LEVELS - 1));
      lvl_b = PW'($urandom_range(0, LEVELS - 1));
      for (int n = 0; n < length; n++) begin
         if (narrow) p = $urandom_range(0, 1) ? lvl_a : lvl_b;
         else p = PW'($urandom_range(0, 7));
         if ($urandom_range(0, 99) < push_pct)
            send_word(mlpf_pkg::CMD_PUSH, random_key(), p);
         else
            send_word(mlpf_pkg::CMD_POP, random_key(), PW'($urandom_range(0, 7)));
      end
   endtask

   initial begin
      int mode;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_word(mlpf_pkg::CMD_POP, 32'hFFFF_FFFF, 3'd7);
      send_word(mlpf_pkg::CMD_PUSH, 32'h0000_0000, 3'd7);
      send_word(mlpf_pkg::CMD_PUSH, 32'hFFFF_FFFF, 3'd0);
      send_word(mlpf_pkg::CMD_PUSH, 32'h5A5A_A5A5, 3'd3);
      send_word(mlpf_pkg::CMD_PUSH, 32'h1234_5678, 3'd7);
      send_word(mlpf_pkg::CMD_PUSH, 32'hA5A5_5A5A, 3'd1);
      send_word(mlpf_pkg::CMD_PUSH, 32'h8000_0001, 3'd2);
      send_word(mlpf_pkg::CMD_PUSH, 32'h7FFF_FFFE, 3'd4);
      send_word(mlpf_pkg::CMD_PUSH, 32'hDEAD_BEEF, 3'd5);
      send_word(mlpf_pkg::CMD_PUSH, 32'hC001_D00D, 3'd6);
      repeat (10) send_word(mlpf_pkg::CMD_POP, random_key(), PW'($urandom_range(0, 7)));
      drain_wait();

      // fill past full, then drain past empty
      run_burst(72, 100, 1'b0);
      drain_wait();
      run_burst(72, 0, 1'b0);
      drain_wait();
      while (words_sent < 920) begin
         mode = $urandom_range(0, 2);
         case (mode)
            0: run_burst($urandom_range(20, 80), 85, $urandom_range(0, 1));
            1: run_burst($urandom_range(20, 80), 20, $urandom_range(0, 1));
            default: run_burst($urandom_range(20, 80), 50, $urandom_range(0, 1));
         endcase
         if ($urandom_range(0, 2) == 0) drain_wait();
      end
      start <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
